// ===== src/robot_pose_kalman_filter_top_assert.svh =====
// Assertion macros for the pose filter. Each macro expects clk and rst_n in scope.
`ifndef ROBOT_POSE_KALMAN_FILTER_TOP_ASSERT_SVH
`define ROBOT_POSE_KALMAN_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RPKF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rpkf_pkg.sv =====
package rpkf_pkg;

  localparam int POS_FRAC_BITS_DEF  = 8;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int COV_FRAC_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF    = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_COS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_SIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 3'd5;

  localparam logic signed [15:0] HEADING_COS_RST   = 16'sd16384;
  localparam logic signed [15:0] HEADING_SIN_RST   = 16'sd0;
  localparam logic signed [23:0] OFFSET_RST        = 24'sd0;
  localparam logic [15:0]        PROCESS_NOISE_RST = 16'd6554;
  localparam logic [15:0]        MEASURE_NOISE_RST = 16'd655;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic [15:0]        process_noise;
    logic [15:0]        measure_noise;
  } rpkf_cfg_t;

  // One transformed position, handed from front to back.
  typedef struct packed {
    logic signed [31:0] gy;
    logic signed [31:0] gx;
  } rpkf_pos_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rpkf_qstat_t;

  // Clamp a wide signed value to the 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    priority if (v > S32_MAX) begin
      res = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      res = S32_MIN[31:0];
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== src/rpkf_front.sv =====
module rpkf_front #(
  parameter int POS_FRAC_BITS  = 8,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpkf_pkg::rpkf_cfg_t cfg,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,
  output logic               q_push,
  output rpkf_pkg::rpkf_pos_t q_wdata,
  input  rpkf_pkg::rpkf_qstat_t q_stat
);
  import rpkf_pkg::*;

  localparam int PW = 48;
  localparam int SW = 49;

  logic               s1_v_r, s1_v_nxt;
  logic               s2_v_r, s2_v_nxt;
  logic signed [31:0] ox_r, oy_r;
  logic signed [PW-1:0] pxc_r, pys_r, pyc_r, pxs_r;
  logic               in_acc, s2_en;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [63:0] off_x, off_y, tot_x, tot_y;

  assign q_push    = s2_v_r && !q_stat.full;
  assign s2_en     = !s2_v_r || q_push;
  assign in_tready = !s1_v_r || s2_en;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s2_en) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_en ? s1_v_r : s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Capture the word, then form the four rotation products.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ox_r <= in_tdata[31:0];
      oy_r <= in_tdata[63:32];
    end
    if (s2_en && s1_v_r) begin
      pxc_r <= ox_r * cfg.heading_cos;
      pys_r <= oy_r * cfg.heading_sin;
      pyc_r <= oy_r * cfg.heading_cos;
      pxs_r <= ox_r * cfg.heading_sin;
    end
  end

  always_comb begin
    sum_x = SW'(pxc_r) + SW'(pys_r);
    sum_y = SW'(pyc_r) - SW'(pxs_r);
    off_x = 64'(cfg.offset_x) <<< POS_FRAC_BITS;
    off_y = 64'(cfg.offset_y) <<< POS_FRAC_BITS;
    tot_x = 64'(sum_x >>> TRIG_FRAC_BITS) + off_x;
    tot_y = 64'(sum_y >>> TRIG_FRAC_BITS) + off_y;
    q_wdata.gx = sat32(tot_x);
    q_wdata.gy = sat32(tot_y);
  end

endmodule

// ===== src/rpkf_queue.sv =====
module rpkf_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  rpkf_pkg::rpkf_pos_t     wdata,
  input  logic                    pop,
  output rpkf_pkg::rpkf_pos_t     rdata,
  output rpkf_pkg::rpkf_qstat_t   stat,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import rpkf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  rpkf_pos_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign count      = cnt_r;

endmodule

// ===== src/rpkf_back.sv =====
module rpkf_back #(
  parameter int POS_FRAC_BITS = 8,
  parameter int COV_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rpkf_pkg::rpkf_cfg_t   cfg,
  input  rpkf_pkg::rpkf_pos_t   q_rdata,
  input  rpkf_pkg::rpkf_qstat_t q_stat,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [127:0]          out_tdata
);
  import rpkf_pkg::*;

  localparam int CF    = COV_FRAC_BITS;
  localparam int CNT_W = $clog2(CF+1);
  localparam int PX_W  = 33 + CF + 2;
  localparam int PP_W  = 2*CF + 2;
  localparam logic [CF:0] ONE     = (CF+1)'(1) << CF;
  localparam logic [CF:0] COV_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_UPD  = 4'b1000
  } rpkf_state_t;

  rpkf_state_t        state_r, state_nxt;
  logic               started_r, started_nxt;
  logic [CF:0]        p_r, p_nxt;
  logic               out_v_r, out_v_nxt;
  logic signed [31:0] est_x_r, est_x_nxt, est_y_r, est_y_nxt;
  logic signed [31:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [CF:0]        pp_r, pp_nxt;
  logic [CF+1:0]      den_r, den_nxt, rem_r, rem_nxt;
  logic [CF:0]        quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic signed [PX_W-1:0] prod_x_r, prod_x_nxt, prod_y_r, prod_y_nxt;
  logic [PP_W-1:0]    prod_p_r, prod_p_nxt;
  logic [127:0]       odata_r, odata_nxt;

  logic [CF+15:0]     q_ext, r_ext;
  logic [CF-1:0]      q_al, r_al;
  logic [CF+1:0]      pp_sum;
  logic [CF:0]        pp_now;
  logic [CF+2:0]      rem2, rem_diff;
  logic               rem_ge;
  logic signed [32:0] res_x, res_y;
  logic signed [63:0] new_x, new_y;
  logic [CF+1:0]      p_shift;
  logic               slot_free;

  // Align q and r to the covariance fraction width.
  assign q_ext = {cfg.process_noise, {CF{1'b0}}};
  assign r_ext = {cfg.measure_noise, {CF{1'b0}}};
  assign q_al  = q_ext[CF+15:16];
  assign r_al  = r_ext[CF+15:16];

  assign pp_sum  = {1'b0, p_r} + (CF+2)'(q_al);
  assign pp_now  = pp_sum[CF+1] ? COV_MAX : pp_sum[CF:0];

  assign rem2     = {rem_r, 1'b0};
  assign rem_diff = rem2 - {1'b0, den_r};
  assign rem_ge   = (rem2 >= {1'b0, den_r});

  assign res_x = 33'(gx_r) - 33'(est_x_r);
  assign res_y = 33'(gy_r) - 33'(est_y_r);
  assign new_x = 64'(est_x_r) + 64'(prod_x_r >>> CF);
  assign new_y = 64'(est_y_r) + 64'(prod_y_r >>> CF);
  assign p_shift = prod_p_r[PP_W-1:CF];

  assign slot_free = !out_v_r || out_tready;
  assign q_pop     = (state_r == ST_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    p_nxt       = p_r;
    out_v_nxt   = out_v_r && !out_tready;
    est_x_nxt   = est_x_r;
    est_y_nxt   = est_y_r;
    gx_nxt      = gx_r;
    gy_nxt      = gy_r;
    pp_nxt      = pp_r;
    den_nxt     = den_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    prod_x_nxt  = prod_x_r;
    prod_y_nxt  = prod_y_r;
    prod_p_nxt  = prod_p_r;
    odata_nxt   = odata_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          gx_nxt  = q_rdata.gx;
          gy_nxt  = q_rdata.gy;
          pp_nxt  = pp_now;
          den_nxt = {1'b0, pp_now} + (CF+2)'(r_al);
          rem_nxt = (CF+2)'(pp_now);
          quo_nxt = '0;
          cnt_nxt = CNT_W'(CF);
          if (!started_r) begin
            est_x_nxt   = sat32(64'(cfg.offset_x) <<< POS_FRAC_BITS);
            est_y_nxt   = sat32(64'(cfg.offset_y) <<< POS_FRAC_BITS);
            started_nxt = 1'b1;
          end
          // With r zero the gain is exactly one, or zero when pp is zero too.
          if (r_al == '0) begin
            quo_nxt   = (pp_now == '0) ? '0 : ONE;
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? rem_diff[CF+1:0] : rem2[CF+1:0];
        quo_nxt = {quo_r[CF-1:0], rem_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_x_nxt = res_x * $signed({1'b0, quo_r});
        prod_y_nxt = res_y * $signed({1'b0, quo_r});
        prod_p_nxt = (ONE - quo_r) * pp_r;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        if (slot_free) begin
          est_x_nxt = sat32(new_x);
          est_y_nxt = sat32(new_y);
          p_nxt     = p_shift[CF+1] ? COV_MAX : p_shift[CF:0];
          odata_nxt = {sat32(new_y), sat32(new_x), gy_r, gx_r};
          out_v_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
      p_r       <= ONE;
      out_v_r   <= 1'b0;
      est_x_r   <= '0;
      est_y_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      p_r       <= p_nxt;
      out_v_r   <= out_v_nxt;
      est_x_r   <= est_x_nxt;
      est_y_r   <= est_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gx_r     <= gx_nxt;
    gy_r     <= gy_nxt;
    pp_r     <= pp_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
    prod_p_r <= prod_p_nxt;
    odata_r  <= odata_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = odata_r;

endmodule

// ===== src/robot_pose_kalman_filter_top.sv =====
// Robot pose filter. Each input word carries one odometer position in the
// robot's local frame (Q24.8 mm). The block rotates it by the configured
// heading (Q1.14 cos/sin), adds the configured offset (whole mm) and returns,
// per word, the global position plus the Kalman-filtered estimate of both
// axes, which share one scalar error variance (Q16). The first word after
// reset seeds the estimate from the offsets with variance 1.0. A front end
// takes one word per cycle, unless the queue is full, into a transform pipe
// (capture register, then rotation product registers) and parks the
// transformed position in a short queue; the back end runs the filter on
// one item at a time: gain divider (one quotient bit per cycle), multiply,
// update; when the measurement noise aligns to zero the divider is bypassed.
// Sustained rate is that of the back end; the queue and the output register
// let the front keep accepting while a result waits. Configuration writes are
// taken every cycle and must only happen while the block is idle; they never
// touch the filter state. No clearing pass follows reset.
module robot_pose_kalman_filter_top #(
  parameter int POS_FRAC_BITS  = rpkf_pkg::POS_FRAC_BITS_DEF,
  parameter int TRIG_FRAC_BITS = rpkf_pkg::TRIG_FRAC_BITS_DEF,
  parameter int COV_FRAC_BITS  = rpkf_pkg::COV_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH    = rpkf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input words: [31:0] odom_x, [63:32] odom_y
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,
  // Result words: [31:0] global_x, [63:32] global_y,
  // [95:64] filtered_x, [127:96] filtered_y
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [127:0]                   out_tdata,
  // Register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpkf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpkf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rpkf_pkg::*;

  `include "robot_pose_kalman_filter_top_assert.svh"

  localparam int QCNT_W = $clog2(QUEUE_DEPTH+1);

  rpkf_cfg_t   cfg_r;
  rpkf_pos_t   q_wdata, q_rdata;
  rpkf_qstat_t q_stat;
  logic        q_push, q_pop;
  logic [QCNT_W-1:0] q_count;

  // Register file: always ready, indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heading_cos   <= HEADING_COS_RST;
      cfg_r.heading_sin   <= HEADING_SIN_RST;
      cfg_r.offset_x      <= OFFSET_RST;
      cfg_r.offset_y      <= OFFSET_RST;
      cfg_r.process_noise <= PROCESS_NOISE_RST;
      cfg_r.measure_noise <= MEASURE_NOISE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADING_COS:   cfg_r.heading_cos   <= cfg_data[15:0];
        CFG_HEADING_SIN:   cfg_r.heading_sin   <= cfg_data[15:0];
        CFG_OFFSET_X:      cfg_r.offset_x      <= cfg_data[23:0];
        CFG_OFFSET_Y:      cfg_r.offset_y      <= cfg_data[23:0];
        CFG_PROCESS_NOISE: cfg_r.process_noise <= cfg_data[15:0];
        CFG_MEASURE_NOISE: cfg_r.measure_noise <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept words, rotate and translate.
  rpkf_front #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_stat   (q_stat)
  );

  // Queue: decouple the transform pipe from the filter.
  rpkf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat),
    .count(q_count)
  );

  // Back: gain division, correction and covariance update.
  rpkf_back #(
    .POS_FRAC_BITS(POS_FRAC_BITS),
    .COV_FRAC_BITS(COV_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  `RPKF_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "queue push while full")
  `RPKF_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty, "queue pop while empty")
  `RPKF_ASSERT_NOW(a_count_bound, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
  `RPKF_ASSERT_NEXT(a_pop_leaves_room, q_pop && !q_push, !q_stat.full, "queue full after pop")

endmodule
